// ----- hdl/stw_pkg.sv -----
// Shared types, constants and the microcode table of the scrolling text window.
// No dependencies; stw_sequencer, the core, the checker and the testbench use this package.
`default_nettype none

package stw_pkg;

    localparam int DEF_TEXT_DEPTH   = 256;
    localparam int DEF_WINDOW_CHARS = 12;

    localparam logic [7:0] GLYPH_COLON = 8'h3A;
    localparam logic [7:0] GLYPH_SPACE = 8'h20;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [3:0] RST_DISPLAY_OFFSET = 4'd0;
    localparam logic [3:0] RST_DISPLAY_CHARS  = 4'd12;
    localparam logic       RST_COLON_PREFIX   = 1'b0;
    localparam logic [7:0] RST_SCROLL_PERIOD  = 8'd5;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_OFFSET = 2'd0,
        CFG_DISPLAY_CHARS  = 2'd1,
        CFG_COLON_PREFIX   = 2'd2,
        CFG_SCROLL_PERIOD  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_FETCH,
        ACT_EXEC,
        ACT_WRAP,
        ACT_EMIT,
        ACT_STATUS
    } act_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NOT_ACCEPT,
        COND_NO_FRAME,
        COND_EMIT_MORE,
        COND_OUT_BUSY
    } cond_t;

    localparam int PC_W = 3;

    localparam logic [PC_W-1:0] STEP_FETCH  = 3'd0;
    localparam logic [PC_W-1:0] STEP_EXEC   = 3'd1;
    localparam logic [PC_W-1:0] STEP_WRAP   = 3'd2;
    localparam logic [PC_W-1:0] STEP_EMIT   = 3'd3;
    localparam logic [PC_W-1:0] STEP_FDONE  = 3'd4;
    localparam logic [PC_W-1:0] STEP_STATUS = 3'd5;
    localparam logic [PC_W-1:0] STEP_SDONE  = 3'd6;

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [PC_W-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic no_frame;
        logic emit_more;
        logic out_busy;
    } flags_t;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] step);
        ctrl_t w;
        w = '{act: ACT_NOP, cond: COND_ALWAYS, target: STEP_FETCH};
        unique case (step)
            STEP_FETCH:  w = '{act: ACT_FETCH,  cond: COND_NOT_ACCEPT, target: STEP_FETCH};
            STEP_EXEC:   w = '{act: ACT_EXEC,   cond: COND_NO_FRAME,   target: STEP_STATUS};
            STEP_WRAP:   w = '{act: ACT_WRAP,   cond: COND_NOT_ACCEPT, target: STEP_EMIT};
            STEP_EMIT:   w = '{act: ACT_EMIT,   cond: COND_EMIT_MORE,  target: STEP_EMIT};
            STEP_FDONE:  w = '{act: ACT_NOP,    cond: COND_ALWAYS,     target: STEP_FETCH};
            STEP_STATUS: w = '{act: ACT_STATUS, cond: COND_OUT_BUSY,   target: STEP_STATUS};
            STEP_SDONE:  w = '{act: ACT_NOP,    cond: COND_ALWAYS,     target: STEP_FETCH};
            default:     w = '{act: ACT_NOP,    cond: COND_ALWAYS,     target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stw_if.sv -----
// Valid/ready channels of the scrolling text window: item input and result output.
// Depends on nothing but the port widths handed in.
`default_nettype none

interface stw_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] glyph_in;
    logic [7:0] repeat_count;

    modport source (output valid, output kind, output glyph_in, output repeat_count,
                    input ready);
    modport sink   (input valid, input kind, input glyph_in, input repeat_count,
                    output ready);
endinterface

interface stw_result_if #(
    parameter int IDX_W = 4
);
    logic             valid;
    logic             ready;
    logic             frame_valid;
    logic [IDX_W-1:0] char_index;
    logic [7:0]       glyph_out;
    logic             last;
    logic [7:0]       repeats_left;

    modport source (output valid, output frame_valid, output char_index, output glyph_out,
                    output last, output repeats_left, input ready);
    modport sink   (input valid, input frame_valid, input char_index, input glyph_out,
                    input last, input repeats_left, output ready);
endinterface

`default_nettype wire

// ----- hdl/stw_text_store.sv -----
// Text byte memory: one write port, one read port with registered read data.
// Depends on nothing outside this file.
`default_nettype none

module stw_text_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/stw_sequencer.sv -----
// Step counter and microcode ROM; produces the control word for the datapath.
// Depends on stw_pkg.
`default_nettype none

module stw_sequencer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire stw_pkg::flags_t flags,
    output stw_pkg::ctrl_t       ctrl
);

    logic [stw_pkg::PC_W-1:0] pc_reg;
    logic [stw_pkg::PC_W-1:0] pc_next;
    logic                     take;

    assign ctrl = stw_pkg::ucode(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            stw_pkg::COND_ALWAYS:     take = 1'b1;
            stw_pkg::COND_NOT_ACCEPT: take = !flags.accept && (ctrl.act == stw_pkg::ACT_FETCH);
            stw_pkg::COND_NO_FRAME:   take = flags.no_frame;
            stw_pkg::COND_EMIT_MORE:  take = flags.emit_more;
            stw_pkg::COND_OUT_BUSY:   take = flags.out_busy;
            default:                  take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= stw_pkg::STEP_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/scrolling_text_window_core.sv -----
// Top level of the scrolling text window: registers, datapath, output stage.
// Depends on stw_pkg, stw_if, stw_text_store and stw_sequencer.
//
//  port    dir   beat carries
//  item    in    kind, glyph_in, repeat_count
//  result  out   frame_valid, char_index, glyph_out, last, repeats_left
//  cfg_*   in    write enable, register index, data (no handshake)
//
// Load, start and non-frame tick: one status beat each.
// Frame tick: WINDOW_CHARS beats, one beat per cycle from the single
// store read port while the result is not stalled.
// A stalled result holds the emit or status step; the next item is taken
// while the last beat still waits. Reset clears all control state; the text
// store is not cleared.
`default_nettype none

module scrolling_text_window_core #(
    parameter int TEXT_DEPTH   = stw_pkg::DEF_TEXT_DEPTH,
    parameter int WINDOW_CHARS = stw_pkg::DEF_WINDOW_CHARS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    stw_item_if.sink                             item,
    stw_result_if.source                         result,
    input  wire logic                            cfg_we,
    input  wire logic [stw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W  = $clog2(TEXT_DEPTH);
    localparam int SLOT_W = $clog2(WINDOW_CHARS);
    localparam logic [PTR_W-1:0]  PTR_FULL  = PTR_W'(TEXT_DEPTH - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_CHARS - 1);

    stw_pkg::ctrl_t  ctrl;
    stw_pkg::flags_t flags;

    logic [3:0]        offset_reg;
    logic [3:0]        chars_reg;
    logic              colon_reg;
    logic [7:0]        period_reg;

    logic [1:0]        kind_reg;
    logic [7:0]        glyph_reg;
    logic [7:0]        repeat_reg;

    logic [PTR_W-1:0]  ptr_reg,    ptr_next;
    logic [PTR_W-1:0]  len_reg,    len_next;
    logic [PTR_W-1:0]  pos_reg,    pos_next;
    logic [PTR_W-1:0]  rd_reg,     rd_next;
    logic [7:0]        tick_reg,   tick_next;
    logic [7:0]        passes_reg, passes_next;
    logic [SLOT_W-1:0] slot_reg,   slot_next;
    logic [3:0]        rem_reg,    rem_next;

    logic              out_valid_reg,  out_valid_next;
    logic              out_frame_reg,  out_frame_next;
    logic [SLOT_W-1:0] out_index_reg,  out_index_next;
    logic [7:0]        out_glyph_reg,  out_glyph_next;
    logic              out_last_reg,   out_last_next;
    logic [7:0]        out_left_reg,   out_left_next;

    logic              accept;
    logic              out_busy;
    logic              fire;
    logic              wr_en;
    logic [7:0]        rd_data;
    logic [7:0]        tick_inc;
    logic              frame_due;
    logic              wrap;
    logic [3:0]        text_count;
    logic              colon_slot;
    logic              text_slot;
    logic              at_end;
    logic [7:0]        glyph_sel;

    stw_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    stw_text_store #(
        .DEPTH  (TEXT_DEPTH),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (glyph_reg),
        .rd_addr (rd_next),
        .rd_data (rd_data)
    );

    assign item.ready = (ctrl.act == stw_pkg::ACT_FETCH);
    assign accept     = item.valid && item.ready;
    assign out_busy   = out_valid_reg && !result.ready;

    assign tick_inc   = tick_reg + 8'd1;
    assign frame_due  = (kind_reg == stw_pkg::KIND_TICK) && (passes_reg != 8'd0)
                        && (tick_inc >= period_reg);
    assign wrap       = (pos_reg >= len_reg);
    assign text_count = (chars_reg > offset_reg) ? chars_reg - offset_reg : 4'd0;

    assign colon_slot = colon_reg && (slot_reg == '0);
    assign text_slot  = !colon_slot && (rem_reg != 4'd0);
    assign at_end     = (rd_reg >= len_reg);
    assign glyph_sel  = colon_slot ? stw_pkg::GLYPH_COLON :
                        (text_slot && !at_end) ? rd_data : stw_pkg::GLYPH_SPACE;

    assign fire  = ((ctrl.act == stw_pkg::ACT_EMIT) || (ctrl.act == stw_pkg::ACT_STATUS))
                   && !out_busy;
    assign wr_en = (ctrl.act == stw_pkg::ACT_EXEC) && (kind_reg == stw_pkg::KIND_LOAD)
                   && (ptr_reg != PTR_FULL);

    always_comb
    begin
        flags.accept    = accept;
        flags.no_frame  = !frame_due;
        flags.emit_more = out_busy || (slot_reg != LAST_SLOT);
        flags.out_busy  = out_busy;
    end

    always_comb
    begin
        ptr_next    = ptr_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        rd_next     = rd_reg;
        tick_next   = tick_reg;
        passes_next = passes_reg;
        slot_next   = slot_reg;
        rem_next    = rem_reg;

        out_valid_next = out_valid_reg && !result.ready;
        out_frame_next = out_frame_reg;
        out_index_next = out_index_reg;
        out_glyph_next = out_glyph_reg;
        out_last_next  = out_last_reg;
        out_left_next  = out_left_reg;

        case (ctrl.act)
            stw_pkg::ACT_EXEC:
            begin
                case (kind_reg)
                    stw_pkg::KIND_LOAD:
                    begin
                        if (ptr_reg != PTR_FULL)
                        begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    stw_pkg::KIND_START:
                    begin
                        len_next    = ptr_reg;
                        ptr_next    = '0;
                        pos_next    = '0;
                        tick_next   = 8'd0;
                        passes_next = repeat_reg;
                    end
                    stw_pkg::KIND_TICK:
                    begin
                        if (passes_reg != 8'd0)
                        begin
                            tick_next = frame_due ? 8'd0 : tick_inc;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            stw_pkg::ACT_WRAP:
            begin
                rd_next   = wrap ? '0 : pos_reg;
                pos_next  = (wrap ? '0 : pos_reg) + 1'b1;
                slot_next = '0;
                rem_next  = text_count;
                if (wrap)
                begin
                    passes_next = passes_reg - 8'd1;
                end
            end
            stw_pkg::ACT_EMIT:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = 1'b1;
                    out_index_next = slot_reg;
                    out_glyph_next = glyph_sel;
                    out_last_next  = (slot_reg == LAST_SLOT);
                    out_left_next  = passes_reg;
                    slot_next      = slot_reg + 1'b1;
                    if (text_slot)
                    begin
                        rem_next = rem_reg - 4'd1;
                        rd_next  = at_end ? '0 : rd_reg + 1'b1;
                    end
                end
            end
            stw_pkg::ACT_STATUS:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = 1'b0;
                    out_index_next = '0;
                    out_glyph_next = 8'd0;
                    out_last_next  = 1'b1;
                    out_left_next  = passes_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= stw_pkg::RST_DISPLAY_OFFSET;
            chars_reg     <= stw_pkg::RST_DISPLAY_CHARS;
            colon_reg     <= stw_pkg::RST_COLON_PREFIX;
            period_reg    <= stw_pkg::RST_SCROLL_PERIOD;
            ptr_reg       <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            rd_reg        <= '0;
            tick_reg      <= 8'd0;
            passes_reg    <= 8'd0;
            slot_reg      <= '0;
            rem_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    stw_pkg::CFG_DISPLAY_OFFSET: offset_reg <= cfg_data[3:0];
                    stw_pkg::CFG_DISPLAY_CHARS:  chars_reg  <= cfg_data[3:0];
                    stw_pkg::CFG_COLON_PREFIX:   colon_reg  <= cfg_data[0];
                    stw_pkg::CFG_SCROLL_PERIOD:  period_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            ptr_reg       <= ptr_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            rd_reg        <= rd_next;
            tick_reg      <= tick_next;
            passes_reg    <= passes_next;
            slot_reg      <= slot_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= item.kind;
            glyph_reg  <= item.glyph_in;
            repeat_reg <= item.repeat_count;
        end
        out_frame_reg <= out_frame_next;
        out_index_reg <= out_index_next;
        out_glyph_reg <= out_glyph_next;
        out_last_reg  <= out_last_next;
        out_left_reg  <= out_left_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_valid  = out_frame_reg;
    assign result.char_index   = out_index_reg;
    assign result.glyph_out    = out_glyph_reg;
    assign result.last         = out_last_reg;
    assign result.repeats_left = out_left_reg;

`ifndef ASSERT_OFF
    a_frame_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_frame_reg && out_last_reg |-> out_index_reg == LAST_SLOT)
        else $error("frame ended before the last slot");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_frame_reg |-> out_last_reg && (out_index_reg == '0))
        else $error("status beat malformed");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctrl.act == stw_pkg::ACT_EXEC)
        else $error("accepted item not executed");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_FULL && len_reg <= PTR_FULL)
        else $error("append pointer past store limit");
`endif

endmodule

`default_nettype wire

// ----- sim/stw_frame_checker.sv -----
`timescale 1ns / 100ps
// Frame checker for the scrolling text window: watches the item, result and register ports,
// predicts every result beat from its own copy of the state and compares field by field.
// Depends on stw_pkg and the channel interfaces of stw_if.

module stw_frame_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    stw_item_if                                  item_mon,
    stw_result_if                                result_mon,
    input  wire logic                            cfg_we,
    input  wire logic [stw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   errors,
    output int                                   outstanding,
    output int                                   frames_checked
);

    localparam int WINDOW = stw_pkg::DEF_WINDOW_CHARS;
    localparam int DEPTH  = stw_pkg::DEF_TEXT_DEPTH;

    typedef struct packed {
        logic       frame_valid;
        logic [3:0] char_index;
        logic [7:0] glyph;
        logic       last;
        logic [7:0] repeats_left;
    } char_beat_t;

    char_beat_t pending_beats[$];
    char_beat_t want;

    logic [7:0] text_mem [DEPTH];
    logic [7:0] wr_ptr     = '0;
    logic [7:0] text_len   = '0;
    logic [7:0] scroll_pos = '0;
    logic [7:0] tick_cnt   = '0;
    logic [7:0] passes     = '0;

    logic [3:0] offset_r = stw_pkg::RST_DISPLAY_OFFSET;
    logic [3:0] chars_r  = stw_pkg::RST_DISPLAY_CHARS;
    logic       colon_r  = stw_pkg::RST_COLON_PREFIX;
    logic [7:0] period_r = stw_pkg::RST_SCROLL_PERIOD;

    int err_cnt   = 0;
    int frame_cnt = 0;
    int beat_cnt  = 0;

    task automatic flag_mismatch(input string field, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
        err_cnt++;
        $display("[%0t] beat %0d: %s expected %h, got %h",
                 $time, beat_cnt, field, exp_v, got_v);
    endtask

    task automatic push_status();
        pending_beats.push_back('{frame_valid: 1'b0, char_index: 4'd0, glyph: 8'd0,
                                  last: 1'b1, repeats_left: passes});
    endtask

    task automatic advance_marquee(input logic [1:0] kind, input logic [7:0] glyph,
                                   input logic [7:0] reps);
        logic [7:0] frame [WINDOW];
        int slot;
        int count;
        int rd;
        case (kind)
            stw_pkg::KIND_LOAD:
            begin
                if (int'(wr_ptr) < DEPTH - 1)
                begin
                    text_mem[wr_ptr] = glyph;
                    wr_ptr = wr_ptr + 8'd1;
                end
                push_status();
            end
            stw_pkg::KIND_START:
            begin
                text_len   = wr_ptr;
                wr_ptr     = '0;
                scroll_pos = '0;
                tick_cnt   = '0;
                passes     = reps;
                push_status();
            end
            stw_pkg::KIND_TICK:
            begin
                if (passes == 8'd0)
                    push_status();
                else
                begin
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt < period_r)
                        push_status();
                    else
                    begin
                        tick_cnt = '0;
                        if (scroll_pos >= text_len)
                        begin
                            scroll_pos = '0;
                            passes = passes - 8'd1;
                        end
                        slot = 0;
                        if (colon_r)
                        begin
                            frame[slot] = stw_pkg::GLYPH_COLON;
                            slot++;
                        end
                        count = (chars_r > offset_r) ? int'(chars_r) - int'(offset_r) : 0;
                        rd = int'(scroll_pos);
                        for (int i = 0; i < count && slot < WINDOW; i++)
                        begin
                            if (rd >= int'(text_len))
                            begin
                                frame[slot] = stw_pkg::GLYPH_SPACE;
                                rd = 0;
                            end
                            else
                            begin
                                frame[slot] = text_mem[rd];
                                rd++;
                            end
                            slot++;
                        end
                        while (slot < WINDOW)
                        begin
                            frame[slot] = stw_pkg::GLYPH_SPACE;
                            slot++;
                        end
                        scroll_pos = scroll_pos + 8'd1;
                        for (int i = 0; i < WINDOW; i++)
                            pending_beats.push_back('{frame_valid: 1'b1,
                                                      char_index: 4'(i),
                                                      glyph: frame[i],
                                                      last: (i == WINDOW - 1),
                                                      repeats_left: passes});
                    end
                end
            end
            default:
                push_status();
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_beats.delete();
            wr_ptr     = '0;
            text_len   = '0;
            scroll_pos = '0;
            tick_cnt   = '0;
            passes     = '0;
            offset_r   = stw_pkg::RST_DISPLAY_OFFSET;
            chars_r    = stw_pkg::RST_DISPLAY_CHARS;
            colon_r    = stw_pkg::RST_COLON_PREFIX;
            period_r   = stw_pkg::RST_SCROLL_PERIOD;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                if (pending_beats.size() == 0)
                    flag_mismatch("beat with nothing pending, glyph_out", 8'd0,
                                  result_mon.glyph_out);
                else
                begin
                    want = pending_beats.pop_front();
                    if (result_mon.frame_valid !== want.frame_valid)
                        flag_mismatch("frame_valid", 8'(want.frame_valid),
                                      8'(result_mon.frame_valid));
                    if (result_mon.char_index !== want.char_index)
                        flag_mismatch("char_index", 8'(want.char_index),
                                      8'(result_mon.char_index));
                    if (result_mon.glyph_out !== want.glyph)
                        flag_mismatch("glyph_out", want.glyph, result_mon.glyph_out);
                    if (result_mon.last !== want.last)
                        flag_mismatch("last", 8'(want.last), 8'(result_mon.last));
                    if (result_mon.repeats_left !== want.repeats_left)
                        flag_mismatch("repeats_left", want.repeats_left,
                                      result_mon.repeats_left);
                    if (want.frame_valid && want.last)
                        frame_cnt++;
                end
                beat_cnt++;
            end
            if (item_mon.valid && item_mon.ready)
                advance_marquee(item_mon.kind, item_mon.glyph_in, item_mon.repeat_count);
            if (cfg_we)
            begin
                case (cfg_index)
                    stw_pkg::CFG_DISPLAY_OFFSET: offset_r = cfg_data[3:0];
                    stw_pkg::CFG_DISPLAY_CHARS:  chars_r  = cfg_data[3:0];
                    stw_pkg::CFG_COLON_PREFIX:   colon_r  = cfg_data[0];
                    stw_pkg::CFG_SCROLL_PERIOD:  period_r = cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        errors         <= err_cnt;
        outstanding    <= pending_beats.size();
        frames_checked <= frame_cnt;
    end

endmodule

// ----- sim/tb_scrolling_text_window_core.sv -----
`timescale 1ns / 100ps
// Testbench top for scrolling_text_window_core: clock, reset, item and register stimulus,
// receiver stalls, watchdog and verdict. Depends on stw_pkg, stw_if and stw_frame_checker.

module tb_scrolling_text_window_core;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_TARGET   = 360;
    localparam int PHASE1_ITEMS  = 45;
    localparam int PHASE2_ITEMS  = 70;
    localparam int ROUND_TICKS   = 16;
    localparam int SETTLE_CYCLES = 24;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [stw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [stw_pkg::CFG_DATA_W-1:0] cfg_data;

    int tx_idle_pct  = 33;
    int rx_idle_pct  = 74;
    int hold_req     = 0;
    int stall_cycles = 0;
    int errors;
    int outstanding;
    int frames_checked;
    int n_loads  = 0;
    int n_starts = 0;
    int n_ticks  = 0;
    int n_unused = 0;

    stw_item_if              item_ch();
    stw_result_if #(.IDX_W(4)) result_ch();

    scrolling_text_window_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stw_frame_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_mon       (item_ch),
        .result_mon     (result_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .outstanding    (outstanding),
        .frames_checked (frames_checked)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin : receiver
        int hold_left;
        int hold_ack;
        hold_left = 0;
        hold_ack  = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req != hold_ack)
            begin
                result_ch.ready <= 1'b0;
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES - 1;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int sent_count();
        return n_loads + n_starts + n_ticks + n_unused;
    endfunction

    task automatic send_beat(input logic [1:0] kind, input logic [7:0] glyph,
                             input logic [7:0] reps);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.glyph_in     <= glyph;
        item_ch.repeat_count <= reps;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        case (kind)
            stw_pkg::KIND_LOAD:  n_loads++;
            stw_pkg::KIND_START: n_starts++;
            stw_pkg::KIND_TICK:  n_ticks++;
            default:             n_unused++;
        endcase
    endtask

    task automatic load_text(input int n);
        repeat (n)
            send_beat(stw_pkg::KIND_LOAD, rnd8(), rnd8());
    endtask

    task automatic tick_run(input int n);
        repeat (n)
            send_beat(stw_pkg::KIND_TICK, rnd8(), rnd8());
    endtask

    // drop valid, wait for every pending beat, then let the block settle
    task automatic quiesce();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_window(input logic [3:0] offset_v, input logic [3:0] width_v,
                              input logic colon_v, input logic [7:0] period_v);
        cfg_we    <= 1'b1;
        cfg_index <= stw_pkg::CFG_DISPLAY_OFFSET;
        cfg_data  <= {4'($urandom_range(0, 15)), offset_v};
        @(posedge clk);
        cfg_index <= stw_pkg::CFG_DISPLAY_CHARS;
        cfg_data  <= {4'($urandom_range(0, 15)), width_v};
        @(posedge clk);
        cfg_index <= stw_pkg::CFG_COLON_PREFIX;
        cfg_data  <= {7'($urandom_range(0, 127)), colon_v};
        @(posedge clk);
        cfg_index <= stw_pkg::CFG_SCROLL_PERIOD;
        cfg_data  <= period_v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_round();
        int pick;
        int offset_v;
        int width_v;
        int period_v;
        int text_len;
        int reps;
        int ticks;
        quiesce();
        pick = $urandom_range(0, 4);
        offset_v = (pick == 0) ? 0 : (pick == 1) ? 11 : (pick == 2) ? 15
                 : $urandom_range(0, 15);
        pick = $urandom_range(0, 5);
        width_v = (pick == 0) ? 1 : (pick == 1) ? 12 : (pick == 2) ? 15
                : (pick == 3) ? 0 : $urandom_range(0, 15);
        period_v = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                 : $urandom_range(0, 3);
        set_window(4'(offset_v), 4'(width_v), 1'($urandom_range(0, 1)), 8'(period_v));
        text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24)
                 : $urandom_range(0, 16);
        load_text(text_len);
        pick = $urandom_range(0, 9);
        reps = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 3);
        send_beat(stw_pkg::KIND_START, rnd8(), 8'(reps));
        ticks = (period_v + 1) * (text_len + 1) * ((reps > 2) ? 2 : reps)
              + $urandom_range(1, 4);
        if (ticks > ROUND_TICKS)
            ticks = ROUND_TICKS;
        repeat (ticks)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_beat(KIND_UNUSED, rnd8(), rnd8());
            else if (pick < 9)
                send_beat(stw_pkg::KIND_LOAD, rnd8(), rnd8());
            else if (pick < 11)
                send_beat(stw_pkg::KIND_START, rnd8(), 8'($urandom_range(0, 3)));
            else
                send_beat(stw_pkg::KIND_TICK, rnd8(), rnd8());
        end
    endtask

    initial
    begin : stimulus
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = stw_pkg::KIND_LOAD;
        item_ch.glyph_in     = '0;
        item_ch.repeat_count = '0;
        cfg_we               = 1'b0;
        cfg_index            = stw_pkg::CFG_DISPLAY_OFFSET;
        cfg_data             = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle tick, unused kind, empty text, then a short text
        send_beat(stw_pkg::KIND_TICK, rnd8(), rnd8());
        send_beat(KIND_UNUSED, rnd8(), rnd8());
        send_beat(stw_pkg::KIND_START, rnd8(), 8'd2);
        tick_run(5);
        send_beat(stw_pkg::KIND_LOAD, 8'h00, rnd8());
        send_beat(stw_pkg::KIND_LOAD, 8'hFF, rnd8());
        send_beat(stw_pkg::KIND_LOAD, 8'h5A, rnd8());
        send_beat(stw_pkg::KIND_START, rnd8(), 8'd255);
        tick_run(5);
        quiesce();
        set_window(4'd0, 4'd15, 1'b1, 8'd0);
        tick_run(2);
        quiesce();
        set_window(4'd11, 4'd3, 1'b1, 8'd1);
        tick_run(1);
        quiesce();
        set_window(4'd11, 4'd12, 1'b0, 8'd1);
        load_text(2);
        send_beat(stw_pkg::KIND_START, rnd8(), 8'd1);
        tick_run(4);

        while (sent_count() < PHASE1_ITEMS)
            random_round();

        tx_idle_pct = 74;
        rx_idle_pct <= 33;
        while (sent_count() < PHASE2_ITEMS)
            random_round();

        // receiver holds off while frames keep coming
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        quiesce();
        set_window(4'd0, 4'd12, 1'b1, 8'd0);
        load_text(5);
        send_beat(stw_pkg::KIND_START, rnd8(), 8'd3);
        hold_req <= hold_req + 1;
        tick_run(20);

        // overfill the text store
        quiesce();
        set_window(4'd0, 4'd12, 1'b0, 8'd1);
        load_text(stw_pkg::DEF_TEXT_DEPTH + 1);
        send_beat(stw_pkg::KIND_START, rnd8(), 8'd1);
        tick_run(4);

        // longest period
        quiesce();
        set_window(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 8'd255);
        tick_run(6);

        while (sent_count() < ITEM_TARGET)
            random_round();

        quiesce();
        $display("items sent: %0d loads, %0d starts, %0d ticks, %0d of the unused kind",
                 n_loads, n_starts, n_ticks, n_unused);
        $display("%0d scroll frames checked, %0d mismatching fields", frames_checked, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/stw_pkg.sv
hdl/stw_if.sv
hdl/stw_text_store.sv
hdl/stw_sequencer.sv
hdl/scrolling_text_window_core.sv
sim/stw_frame_checker.sv
sim/tb_scrolling_text_window_core.sv
